### rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`default_nettype none

package u8u16_pkg;

  // Lead byte boundaries
  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT = 8'hF5;

  // Payload masks of lead and continuation bytes
  localparam logic [7:0] MASK_TWO   = 8'h1F;
  localparam logic [7:0] MASK_THREE = 8'h0F;
  localparam logic [7:0] MASK_FOUR  = 8'h07;
  localparam logic [7:0] MASK_CONT  = 8'h3F;

  // Surrogate arithmetic
  localparam logic [31:0] PLANE_OFFSET = 32'h0001_0000;
  localparam logic [15:0] SURR_HIGH    = 16'hD800;
  localparam logic [15:0] SURR_LOW     = 16'hDC00;
  localparam logic [15:0] SURR_MASK    = 16'h03FF;

  // Sequence length codes (total length minus one)
  localparam logic [1:0] SEQ_NONE  = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_run;
    logic        string_done;
    logic        truncated;
  } result_t;

endpackage

`default_nettype wire

### rtl/u8u16_in_if.sv
// Byte channel carrying UTF-8 input items.
`default_nettype none

interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/u8u16_out_if.sv
// Unit channel carrying UTF-16 result items.
`default_nettype none

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_run;
  logic        string_done;
  logic        truncated;

  modport source (output valid, output code_unit, output end_of_run,
                  output string_done, output truncated, input ready);
  modport sink   (input valid, input code_unit, input end_of_run,
                  input string_done, input truncated, output ready);
endinterface

`default_nettype wire

### rtl/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder.
`default_nettype none

// Takes one UTF-8 byte per item and returns UTF-16 units. Bytes are
// registered, decoded combinationally against the sequence state and the
// resulting units (none, one, two for a surrogate pair, plus the zero
// terminator after the last byte) are loaded into a three-entry result
// queue that drives the output channel one unit per cycle while the
// output is ready. One byte is taken every cycle while each byte yields at
// most one unit and the output is ready; a byte that yields more than one
// unit holds the next byte until its units have drained from the queue. A byte
// can still be taken while a unit waits at the output.
module utf8_to_utf16_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  u8u16_in_if.sink         bytes,
  u8u16_out_if.source      units
);
  import u8u16_pkg::*;

  // Input register
  logic       in_vld;
  logic [7:0] in_b;
  logic       in_last;

  // Sequence state
  logic [20:0] acc;
  logic [1:0]  rem;
  logic [1:0]  len;
  logic [20:0] acc_next;
  logic [1:0]  rem_next;
  logic [1:0]  len_next;

  // Result queue
  result_t     out_q [3];
  logic [1:0]  out_cnt;

  // Decode results
  result_t     res [3];
  logic [1:0]  res_n;
  logic [1:0]  pay_n;
  logic [15:0] pay0;
  logic [15:0] pay1;
  logic [20:0] acc_cont;
  logic [31:0] surr_v;
  result_t     term;

  logic pop;
  logic advance;
  logic take;

  assign pop     = (out_cnt != 2'd0) && units.ready;
  assign advance = in_vld && ((out_cnt == 2'd0) || ((out_cnt == 2'd1) && pop));
  assign take    = bytes.valid && bytes.ready;

  assign bytes.ready = !in_vld || advance;

  assign acc_cont = {acc[14:0], in_b[5:0]};
  assign surr_v   = {11'd0, acc_cont} - PLANE_OFFSET;

  always_comb begin
    acc_next = acc;
    rem_next = rem;
    len_next = len;
    pay_n    = 2'd0;
    pay0     = '0;
    pay1     = '0;
    if (rem == 2'd0) begin
      if ((in_b < LEAD_TWO) || (in_b >= LEAD_LIMIT)) begin
        pay_n = 2'd1;
        pay0  = {8'd0, in_b};
      end else if (in_b < LEAD_THREE) begin
        acc_next = {13'd0, in_b & MASK_TWO};
        rem_next = 2'd1;
        len_next = SEQ_TWO;
      end else if (in_b < LEAD_FOUR) begin
        acc_next = {13'd0, in_b & MASK_THREE};
        rem_next = 2'd2;
        len_next = SEQ_THREE;
      end else begin
        acc_next = {13'd0, in_b & MASK_FOUR};
        rem_next = 2'd3;
        len_next = SEQ_FOUR;
      end
    end else begin
      acc_next = acc_cont;
      rem_next = rem - 2'd1;
      if (rem == 2'd1) begin
        if (len == SEQ_FOUR) begin
          pay_n = 2'd2;
          pay0  = surr_v[25:10] | SURR_HIGH;
          pay1  = (surr_v[15:0] & SURR_MASK) | SURR_LOW;
        end else begin
          pay_n = 2'd1;
          pay0  = acc_cont[15:0];
        end
        acc_next = '0;
        len_next = SEQ_NONE;
      end
    end

    term.code_unit   = '0;
    term.end_of_run  = 1'b1;
    term.string_done = 1'b1;
    term.truncated   = (rem_next != 2'd0);

    // Terminator follows the payload units when this is the last byte
    res_n = pay_n + {1'b0, in_last};
    res[0].code_unit   = pay0;
    res[0].end_of_run  = (res_n == 2'd1);
    res[0].string_done = 1'b0;
    res[0].truncated   = 1'b0;
    res[1].code_unit   = pay1;
    res[1].end_of_run  = (res_n == 2'd2);
    res[1].string_done = 1'b0;
    res[1].truncated   = 1'b0;
    res[2]             = term;
    if (pay_n == 2'd0) begin
      res[0] = term;
    end
    if (pay_n != 2'd2) begin
      res[1] = term;
    end

    if (in_last) begin
      acc_next = '0;
      rem_next = 2'd0;
      len_next = SEQ_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_b    <= bytes.in_byte;
      in_last <= bytes.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      rem <= 2'd0;
      len <= SEQ_NONE;
    end else if (advance) begin
      acc <= acc_next;
      rem <= rem_next;
      len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (advance) begin
      out_cnt <= res_n;
    end else if (pop) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  // Advance only happens once the queue is (or is becoming) empty
  always_ff @(posedge clk) begin
    if (advance) begin
      out_q[0] <= res[0];
      out_q[1] <= res[1];
      out_q[2] <= res[2];
    end else if (pop) begin
      out_q[0] <= out_q[1];
      out_q[1] <= out_q[2];
    end
  end

  assign units.valid       = (out_cnt != 2'd0);
  assign units.code_unit   = out_q[0].code_unit;
  assign units.end_of_run  = out_q[0].end_of_run;
  assign units.string_done = out_q[0].string_done;
  assign units.truncated   = out_q[0].truncated;

endmodule

`default_nettype wire

### rtl/u8u16_checker.sv
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to its top level.
`default_nettype none

module u8u16_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        units_valid,
  input wire logic        units_ready,
  input wire logic [15:0] units_code_unit,
  input wire logic        units_end_of_run,
  input wire logic        units_string_done,
  input wire logic        units_truncated
);

  // Nothing left in flight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !units_valid)
    else $error("unit offered straight after reset");

  // The terminator closes the run of its byte and carries a zero unit
  a_term_closes: assert property (@(posedge clk) disable iff (rst)
    (units_valid && units_string_done) |-> (units_end_of_run && units_code_unit == 16'd0))
    else $error("terminator not zero or not last of its run");

  // Truncation is only reported on a terminator
  a_trunc_term: assert property (@(posedge clk) disable iff (rst)
    (units_valid && units_truncated) |-> units_string_done)
    else $error("truncated flag outside a terminator");

  // A stalled unit holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (units_valid && !units_ready) |=> (units_valid && $stable(units_code_unit)
      && $stable(units_end_of_run) && $stable(units_string_done)))
    else $error("stalled unit changed");

endmodule

bind utf8_to_utf16_decoder u8u16_checker chk (
  .clk               (clk),
  .rst               (rst),
  .units_valid       (units.valid),
  .units_ready       (units.ready),
  .units_code_unit   (units.code_unit),
  .units_end_of_run  (units.end_of_run),
  .units_string_done (units.string_done),
  .units_truncated   (units.truncated)
);

`default_nettype wire

### test/tb.sv
// Testbench for the UTF-8 to UTF-16 decoder: directed and random byte strings, unit checks.
`timescale 1ns / 100ps

module tb;
  import u8u16_pkg::*;

  localparam int RANDOM_BYTES = 460;
  localparam int STEADY_FROM  = 200;
  localparam int STEADY_TO    = 330;

  // {last_byte, in_byte}
  localparam logic [8:0] DIRECTED [25] = '{
    9'h000, 9'h07F, 9'h080, 9'h0BF, 9'h0F5, 9'h1FF,   // stray bytes, last on a stray
    9'h0DF, 9'h0BF,                                    // largest 2-byte value
    9'h0EF, 9'h0BF, 9'h0BF,                            // full 16 bits from 3 bytes
    9'h0F0, 9'h080, 9'h080, 9'h080,                    // value below plane 1, wraps
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,                    // pair plus terminator
    9'h0C0, 9'h1E9,                                    // lead byte as continuation
    9'h0E0, 9'h182,                                    // ends inside a sequence
    9'h1F0,                                            // ends right after a lead
    9'h141
  };

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         steady;  // no idling on either side while this item is at the head
    bit         drain;   // hold the sender until every unit has come back
  } byte_item_t;

  logic clk;
  logic rst;

  u8u16_in_if  byte_ch ();
  u8u16_out_if unit_ch ();

  utf8_to_utf16_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .units (unit_ch)
  );

  byte_item_t  bytes_to_send [$];
  result_t     pending_units [$];
  bit          byte_held;
  int          item_count;
  int          mismatches;

  // decoder state mirror
  logic [20:0] acc_bits;
  logic [1:0]  conts_left;
  logic [1:0]  seq_len;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic decode_byte(input logic [7:0] b, input logic last);
    result_t     units [3];
    int          n;
    logic [31:0] offs;
    n = 0;
    if (conts_left == 2'd0) begin
      if (b < LEAD_TWO || b >= LEAD_LIMIT) begin
        units[n] = '{code_unit: {8'h00, b}, default: 1'b0};
        n++;
      end else if (b < LEAD_THREE) begin
        acc_bits = 21'(b & MASK_TWO);
        conts_left = 2'd1;
        seq_len = SEQ_TWO;
      end else if (b < LEAD_FOUR) begin
        acc_bits = 21'(b & MASK_THREE);
        conts_left = 2'd2;
        seq_len = SEQ_THREE;
      end else begin
        acc_bits = 21'(b & MASK_FOUR);
        conts_left = 2'd3;
        seq_len = SEQ_FOUR;
      end
    end else begin
      acc_bits = {acc_bits[14:0], b[5:0]};
      conts_left = conts_left - 2'd1;
      if (conts_left == 2'd0) begin
        if (seq_len == SEQ_FOUR) begin
          offs = {11'd0, acc_bits} - PLANE_OFFSET;
          units[n] = '{code_unit: offs[25:10] | SURR_HIGH, default: 1'b0};
          n++;
          units[n] = '{code_unit: (offs[15:0] & SURR_MASK) | SURR_LOW, default: 1'b0};
          n++;
        end else begin
          units[n] = '{code_unit: acc_bits[15:0], default: 1'b0};
          n++;
        end
        acc_bits = '0;
        seq_len = SEQ_NONE;
      end
    end
    if (last) begin
      units[n] = '{code_unit: 16'h0000, end_of_run: 1'b0, string_done: 1'b1,
                   truncated: conts_left != 2'd0};
      n++;
      acc_bits = '0;
      conts_left = 2'd0;
      seq_len = SEQ_NONE;
    end
    if (n > 0) units[n-1].end_of_run = 1'b1;
    for (int i = 0; i < n; i++) pending_units.push_back(units[i]);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    byte_item_t it;
    it = '{data: b, last: last,
           steady: item_count >= STEADY_FROM && item_count < STEADY_TO, drain: 1'b0};
    bytes_to_send.push_back(it);
    item_count++;
  endtask

  // One string of mostly well-formed sequences, with noise and cut-off sequences mixed in.
  task automatic add_string();
    logic [7:0] str [$];
    int         nsym;
    int         kind;
    int         len;
    int         nconts;
    bit         cut;
    nsym = $urandom_range(1, 10);
    cut = 1'b0;
    for (int s = 0; s < nsym && !cut; s++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        str.push_back(8'($urandom_range(8'h00, 8'h7F)));
      end else if (kind < 50) begin
        str.push_back(8'($urandom_range(8'h00, 8'hFF)));
      end else begin
        if (kind < 66) begin
          len = 2;
          str.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        end else if (kind < 83) begin
          len = 3;
          str.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        end else begin
          len = 4;
          str.push_back(8'($urandom_range(8'hF0, 8'hF4)));
        end
        cut = $urandom_range(0, 11) == 0;
        nconts = cut ? $urandom_range(0, len - 2) : len - 1;
        for (int k = 0; k < nconts; k++) begin
          if ($urandom_range(0, 6) == 0) str.push_back(8'($urandom_range(8'h00, 8'hFF)));
          else str.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
      end
    end
    foreach (str[i]) add_byte(str[i], i == str.size() - 1);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_held) begin
      if (bytes_to_send.size() > 0 && bytes_to_send[0].drain) begin
        byte_ch.valid <= 1'b0;
        if (pending_units.size() == 0) void'(bytes_to_send.pop_front());
      end else if (bytes_to_send.size() > 0 &&
                   (bytes_to_send[0].steady || $urandom_range(0, 99) >= 20)) begin
        byte_ch.valid     <= 1'b1;
        byte_ch.in_byte   <= bytes_to_send[0].data;
        byte_ch.last_byte <= bytes_to_send[0].last;
        byte_held = 1'b1;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      decode_byte(byte_ch.in_byte, byte_ch.last_byte);
      void'(bytes_to_send.pop_front());
      byte_held = 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      unit_ch.ready <= 1'b0;
    end else begin
      unit_ch.ready <= (bytes_to_send.size() > 0 && bytes_to_send[0].steady) ||
                       $urandom_range(0, 99) >= 20;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && unit_ch.valid && unit_ch.ready) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected unit, expected none, got %h eor=%b done=%b trunc=%b",
                 $time, unit_ch.code_unit, unit_ch.end_of_run, unit_ch.string_done,
                 unit_ch.truncated);
        mismatches++;
      end else begin
        want = pending_units.pop_front();
        if (unit_ch.code_unit !== want.code_unit || unit_ch.end_of_run !== want.end_of_run ||
            unit_ch.string_done !== want.string_done ||
            unit_ch.truncated !== want.truncated) begin
          $display({"%0t: unit mismatch, expected %h eor=%b done=%b trunc=%b,",
                    " got %h eor=%b done=%b trunc=%b"},
                   $time, want.code_unit, want.end_of_run, want.string_done, want.truncated,
                   unit_ch.code_unit, unit_ch.end_of_run, unit_ch.string_done,
                   unit_ch.truncated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    byte_item_t pause;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.in_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    unit_ch.ready = 1'b0;
    byte_held = 1'b0;
    item_count = 0;
    mismatches = 0;
    acc_bits = '0;
    conts_left = 2'd0;
    seq_len = SEQ_NONE;

    foreach (DIRECTED[i]) add_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    pause = '{data: 8'h00, last: 1'b0, steady: 1'b0, drain: 1'b1};
    bytes_to_send.push_back(pause);
    while (item_count < RANDOM_BYTES + $size(DIRECTED)) add_string();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (bytes_to_send.size() > 0 || byte_held) @(posedge clk);
    while (pending_units.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
